>>> sv/tgdlp_pkg.sv
// ----------------------------------------------------------------------------
// tgdlp_pkg
// Shared constants and controller/datapath interface types for the touch
// grid debounce and long-press unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tgdlp_pkg;

  // Field widths
  localparam int unsigned COORD_BITS_DEF = 10;  // default raw coordinate width
  localparam int unsigned CELL_BITS      = 10;  // column / row width
  localparam int unsigned SIZE_BITS      = 11;  // cell width / height
  localparam int unsigned RUN_BITS       = 8;   // debounce run lengths
  localparam int unsigned COUNT_BITS     = 16;  // touched-sample counter

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_CELL_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CELL_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRESS_RUNS   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_RUNS = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_LIMIT   = 3'd4;

  // Register reset values
  localparam logic [SIZE_BITS-1:0]  RST_CELL_SIZE  = 11'd1;
  localparam logic [RUN_BITS-1:0]   RST_RUNS       = 8'd10;
  localparam logic [COUNT_BITS-1:0] RST_LONG_LIMIT = 16'd500;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;    // capture the sample, start both dividers
    logic step;    // one restoring-division step
    logic update;  // apply the debounce update, may emit a result
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic emit_due;  // the pending update releases a result
    logic out_free;  // output register can take a result this cycle
  } dp_sts_t;

endpackage : tgdlp_pkg

`default_nettype wire

>>> sv/tgdlp_ctrl.sv
// ----------------------------------------------------------------------------
// tgdlp_ctrl
// Sequencer: accepts one sample, runs the serial dividers for one step per
// quotient bit, then applies the debounce update once any result it releases can go out.
// ----------------------------------------------------------------------------
`default_nettype none

module tgdlp_ctrl #(
  parameter int unsigned COORD_BITS = tgdlp_pkg::COORD_BITS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  tgdlp_pkg::dp_sts_t  sts_i,
  output tgdlp_pkg::dp_cmd_t  cmd_o
);
  import tgdlp_pkg::*;

  // Quotient width: at least wide enough for the column / row field
  localparam int unsigned QW = (COORD_BITS > CELL_BITS) ? COORD_BITS : CELL_BITS;
  localparam int unsigned CW = $clog2(QW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = CW'(QW - 1);
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_UPD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_UPD: begin
        // hold while a due result cannot enter the output register
        if (!sts_i.emit_due || sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Assertions
  a_upd_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> (!sts_i.emit_due || sts_i.out_free))
    else $error("update issued while output register is occupied");

  a_accept_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_DIV))
    else $error("accepted beat did not start division");

  a_div_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_UPD))
    else $error("division did not finish into update");

endmodule : tgdlp_ctrl

`default_nettype wire

>>> sv/tgdlp_dp.sv
// ----------------------------------------------------------------------------
// tgdlp_dp
// Datapath: configuration registers, two restoring dividers (one quotient
// bit per step), debounce counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgdlp_dp #(
  parameter int unsigned COORD_BITS = tgdlp_pkg::COORD_BITS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // configuration
  input  wire                                   cfg_we_i,
  input  wire  [tgdlp_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire  [tgdlp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  // sample
  input  wire  [COORD_BITS-1:0]                 touch_x_i,
  input  wire  [COORD_BITS-1:0]                 touch_y_i,
  input  wire                                   touched_i,
  // control
  input  tgdlp_pkg::dp_cmd_t                    cmd_i,
  output tgdlp_pkg::dp_sts_t                    sts_o,
  // result
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [tgdlp_pkg::CELL_BITS-1:0]       column_o,
  output logic [tgdlp_pkg::CELL_BITS-1:0]       row_o,
  output logic                                  long_press_o
);
  import tgdlp_pkg::*;

  localparam int unsigned QW = (COORD_BITS > CELL_BITS) ? COORD_BITS : CELL_BITS;

  // Configuration registers
  logic [SIZE_BITS-1:0]  cell_w_q, cell_h_q;
  logic [RUN_BITS-1:0]   press_runs_q, release_runs_q;
  logic [COUNT_BITS-1:0] long_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_w_q       <= RST_CELL_SIZE;
      cell_h_q       <= RST_CELL_SIZE;
      press_runs_q   <= RST_RUNS;
      release_runs_q <= RST_RUNS;
      long_limit_q   <= RST_LONG_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CELL_WIDTH:   cell_w_q       <= cfg_wdata_i[SIZE_BITS-1:0];
        REG_CELL_HEIGHT:  cell_h_q       <= cfg_wdata_i[SIZE_BITS-1:0];
        REG_PRESS_RUNS:   press_runs_q   <= cfg_wdata_i[RUN_BITS-1:0];
        REG_RELEASE_RUNS: release_runs_q <= cfg_wdata_i[RUN_BITS-1:0];
        REG_LONG_LIMIT:   long_limit_q   <= cfg_wdata_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Zero sizes and runs act as one
  logic [SIZE_BITS-1:0] div_x, div_y;
  logic [RUN_BITS-1:0]  pr_eff, rr_eff;

  assign div_x  = (cell_w_q == '0) ? SIZE_BITS'(1) : cell_w_q;
  assign div_y  = (cell_h_q == '0) ? SIZE_BITS'(1) : cell_h_q;
  assign pr_eff = (press_runs_q == '0) ? RUN_BITS'(1) : press_runs_q;
  assign rr_eff = (release_runs_q == '0) ? RUN_BITS'(1) : release_runs_q;

  // Restoring dividers: quotient shifts in where the dividend shifts out
  logic [QW-1:0]        quo_x_q, quo_y_q, quo_x_d, quo_y_d;
  logic [SIZE_BITS-1:0] rem_x_q, rem_y_q, rem_x_d, rem_y_d;
  logic [SIZE_BITS:0]   trial_x, trial_y, diff_x, diff_y;
  logic                 ge_x, ge_y;
  logic                 touched_q;

  always_comb begin
    trial_x = {rem_x_q, quo_x_q[QW-1]};
    trial_y = {rem_y_q, quo_y_q[QW-1]};
    diff_x  = trial_x - {1'b0, div_x};
    diff_y  = trial_y - {1'b0, div_y};
    ge_x    = (trial_x >= {1'b0, div_x});
    ge_y    = (trial_y >= {1'b0, div_y});
    rem_x_d = ge_x ? diff_x[SIZE_BITS-1:0] : trial_x[SIZE_BITS-1:0];
    rem_y_d = ge_y ? diff_y[SIZE_BITS-1:0] : trial_y[SIZE_BITS-1:0];
    quo_x_d = {quo_x_q[QW-2:0], ge_x};
    quo_y_d = {quo_y_q[QW-2:0], ge_y};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_x_q   <= QW'(touch_x_i);
      quo_y_q   <= QW'(touch_y_i);
      rem_x_q   <= '0;
      rem_y_q   <= '0;
      touched_q <= touched_i;
    end else if (cmd_i.step) begin
      quo_x_q <= quo_x_d;
      quo_y_q <= quo_y_d;
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
    end
  end

  // Debounce state
  logic                  phase_q, phase_d;
  logic [COUNT_BITS-1:0] press_q, press_d, press_inc;
  logic [RUN_BITS-1:0]   rel_q, rel_d, rel_inc;
  logic [CELL_BITS-1:0]  last_col_q, last_row_q;
  logic                  record, emit;

  assign press_inc = (press_q == '1) ? press_q : press_q + 1'b1;
  assign rel_inc   = (rel_q == '1) ? rel_q : rel_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    press_d = press_q;
    rel_d   = rel_q;
    record  = touched_q;
    emit    = 1'b0;
    if (!phase_q) begin
      press_d = touched_q ? press_inc : '0;
      if (press_d >= COUNT_BITS'(pr_eff)) begin
        phase_d = 1'b1;
        rel_d   = '0;
      end
    end else if (touched_q) begin
      rel_d   = '0;
      press_d = press_inc;
    end else begin
      rel_d = rel_inc;
      if (rel_inc >= rr_eff) begin
        emit    = 1'b1;
        phase_d = 1'b0;
        press_d = '0;
        rel_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      press_q    <= '0;
      rel_q      <= '0;
      last_col_q <= '0;
      last_row_q <= '0;
    end else if (cmd_i.update) begin
      phase_q <= phase_d;
      press_q <= press_d;
      rel_q   <= rel_d;
      if (record) begin
        last_col_q <= quo_x_q[CELL_BITS-1:0];
        last_row_q <= quo_y_q[CELL_BITS-1:0];
      end
    end
  end

  // Output register
  logic out_valid_q;
  logic out_load;

  assign sts_o.emit_due = emit;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_load       = cmd_i.update && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      column_o     <= last_col_q;
      row_o        <= last_row_q;
      long_press_o <= (press_q > long_limit_q);
    end
  end

  assign out_valid_o = out_valid_q;

  // Assertions
  a_rel_idle_in_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !phase_q |-> (rel_q == '0))
    else $error("release count nonzero while waiting for press");

endmodule : tgdlp_dp

`default_nettype wire

>>> sv/touch_grid_debounce_long_press_unit.sv
// Sequence: an accepted beat loads both dividers, steps them once per
//   quotient bit and then applies its state update; a releasing beat's result
//   is registered at that update and is valid from then on.
// Input: a new beat stalls until the last beat's update; the serial dividers
//   take one column/row quotient bit per cycle, and a releasing beat waits
//   longer while an earlier result sits stalled in the output register.
// Reset: asynchronous active-low; clears debounce state and loads defaults.
// ----------------------------------------------------------------------------
// touch_grid_debounce_long_press_unit
// Debounces touch samples into press/release gestures, maps each touched
// sample to a grid cell and reports the last cell with a long-press flag.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_grid_debounce_long_press_unit #(
  parameter int unsigned COORD_BITS = tgdlp_pkg::COORD_BITS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // configuration
  input  wire                                   cfg_we_i,
  input  wire  [tgdlp_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire  [tgdlp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  // sample channel
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [COORD_BITS-1:0]                 touch_x_i,
  input  wire  [COORD_BITS-1:0]                 touch_y_i,
  input  wire                                   touched_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [tgdlp_pkg::CELL_BITS-1:0]       column_o,
  output logic [tgdlp_pkg::CELL_BITS-1:0]       row_o,
  output logic                                  long_press_o
);
  import tgdlp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  tgdlp_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Dividers, counters and output register
  tgdlp_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .touch_x_i    (touch_x_i),
    .touch_y_i    (touch_y_i),
    .touched_i    (touched_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .column_o     (column_o),
    .row_o        (row_o),
    .long_press_o (long_press_o)
  );

endmodule : touch_grid_debounce_long_press_unit

`default_nettype wire

>>> tb/sv/tgdlp_gesture_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tgdlp_gesture_checker
// Passive monitor for the touch grid debounce unit. It shadows every
// register write, runs its own debounce and cell-mapping model on each
// accepted sample beat, queues the release reports that model produces and
// compares every accepted result beat with the oldest queued report.
// ----------------------------------------------------------------------------
module tgdlp_gesture_checker #(
  parameter int unsigned COORD_BITS = tgdlp_pkg::COORD_BITS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration port, observed
  input  wire                                 cfg_we_i,
  input  wire [tgdlp_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire [tgdlp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  // sample channel, observed
  input  wire                                 in_valid_i,
  input  wire                                 in_stall_i,
  input  wire [COORD_BITS-1:0]                touch_x_i,
  input  wire [COORD_BITS-1:0]                touch_y_i,
  input  wire                                 touched_i,
  // result channel, observed
  input  wire                                 out_valid_i,
  input  wire                                 out_stall_i,
  input  wire [tgdlp_pkg::CELL_BITS-1:0]      column_i,
  input  wire [tgdlp_pkg::CELL_BITS-1:0]      row_i,
  input  wire                                 long_press_i,
  // to the testbench top
  output int unsigned                         error_count_o,
  output int unsigned                         reports_due_o
);
  import tgdlp_pkg::*;

  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    logic [CELL_BITS-1:0] column;
    logic [CELL_BITS-1:0] row;
    logic                 long_press;
  } cell_report_t;

  // shadow registers
  logic [SIZE_BITS-1:0]  cell_w;
  logic [SIZE_BITS-1:0]  cell_h;
  logic [RUN_BITS-1:0]   press_len;
  logic [RUN_BITS-1:0]   release_len;
  logic [COUNT_BITS-1:0] long_limit;

  // gesture state
  logic                  holding;      // 1 = press accepted, waiting for release
  logic [COUNT_BITS-1:0] touch_total;  // touched samples in this gesture
  logic [RUN_BITS-1:0]   lift_run;     // untouched run while holding
  logic [CELL_BITS-1:0]  cell_col;
  logic [CELL_BITS-1:0]  cell_row;

  cell_report_t report_q[$];
  int unsigned  errors;

  // zero sizes and run lengths behave as one
  function automatic int unsigned nonzero(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  task automatic map_cell(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    cell_col = CELL_BITS'(int'(x) / nonzero(cell_w));
    cell_row = CELL_BITS'(int'(y) / nonzero(cell_h));
  endtask

  task automatic shadow_write(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_CELL_WIDTH:   cell_w      = data[SIZE_BITS-1:0];
      REG_CELL_HEIGHT:  cell_h      = data[SIZE_BITS-1:0];
      REG_PRESS_RUNS:   press_len   = data[RUN_BITS-1:0];
      REG_RELEASE_RUNS: release_len = data[RUN_BITS-1:0];
      REG_LONG_LIMIT:   long_limit  = data[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // debounce update for one sample beat; queues a report on release
  task automatic track_sample(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic t);
    cell_report_t rep;
    if (t) begin
      map_cell(x, y);
      if (touch_total != '1) touch_total++;
    end
    if (!holding) begin
      if (!t) touch_total = '0;
      if (touch_total >= nonzero(press_len)) begin
        holding  = 1'b1;
        lift_run = '0;
      end
    end else if (t) begin
      lift_run = '0;
    end else begin
      if (lift_run != '1) lift_run++;
      if (lift_run >= nonzero(release_len)) begin
        rep.column     = cell_col;
        rep.row        = cell_row;
        rep.long_press = (touch_total > long_limit);
        report_q.push_back(rep);
        holding     = 1'b0;
        touch_total = '0;
        lift_run    = '0;
      end
    end
  endtask

  task automatic check_report();
    cell_report_t want;
    if (report_q.size() == 0) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: unexpected result: column %0d row %0d long %0b",
                 $time, column_i, row_i, long_press_i);
    end else begin
      want = report_q.pop_front();
      if (want.column !== column_i || want.row !== row_i ||
          want.long_press !== long_press_i) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: result mismatch: column %0d/%0d row %0d/%0d long %0b/%0b (exp/act)",
                   $time, want.column, column_i, want.row, row_i,
                   want.long_press, long_press_i);
      end
    end
  endtask

  // sample both channels and the config port at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_w      = RST_CELL_SIZE;
      cell_h      = RST_CELL_SIZE;
      press_len   = RST_RUNS;
      release_len = RST_RUNS;
      long_limit  = RST_LONG_LIMIT;
      holding     = 1'b0;
      touch_total = '0;
      lift_run    = '0;
      cell_col    = '0;
      cell_row    = '0;
      report_q.delete();
      errors      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_report();
      if (cfg_we_i) shadow_write(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) track_sample(touch_x_i, touch_y_i, touched_i);
    end
    error_count_o <= errors;
    reports_due_o <= report_q.size();
  end

endmodule

>>> tb/sv/tb_touch_grid_debounce_long_press_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_grid_debounce_long_press_unit
// Drives touch sample beats and register settings into the debounce unit,
// with random idling on both channels, a long output hold-off and a long
// press gesture just past the limit. The gesture checker beside the block
// predicts and compares the release reports; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_touch_grid_debounce_long_press_unit;
  import tgdlp_pkg::*;

  localparam int unsigned COORD_W      = COORD_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned QUIET_CYCLES = 40;     // longer than one beat's full processing
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned RANDOM_BEATS = 440;
  localparam int unsigned LONG_TOUCHES = 257;    // past a limit of 256

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  logic               in_valid = 1'b0;
  wire                in_stall;
  logic [COORD_W-1:0] touch_x  = '0;
  logic [COORD_W-1:0] touch_y  = '0;
  logic               touched  = 1'b0;

  wire                 out_valid;
  logic                out_stall = 1'b0;
  wire [CELL_BITS-1:0] column;
  wire [CELL_BITS-1:0] row;
  wire                 long_press;

  int unsigned error_count;
  int unsigned reports_due;

  // stimulus control
  logic        calm          = 1'b0;  // no idling on either side
  int unsigned hold_requests = 0;
  int unsigned beats_sent    = 0;
  int unsigned press_need    = 10;
  int unsigned release_need  = 10;
  int unsigned cycle_count   = 0;

  touch_grid_debounce_long_press_unit #(
    .COORD_BITS (COORD_W)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .touch_x_i    (touch_x),
    .touch_y_i    (touch_y),
    .touched_i    (touched),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .column_o     (column),
    .row_o        (row),
    .long_press_o (long_press)
  );

  tgdlp_gesture_checker #(
    .COORD_BITS (COORD_W)
  ) u_gesture_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .touch_x_i     (touch_x),
    .touch_y_i     (touch_y),
    .touched_i     (touched),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .column_i      (column),
    .row_i         (row),
    .long_press_i  (long_press),
    .error_count_o (error_count),
    .reports_due_o (reports_due)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("touch_grid_debounce_long_press_unit regression: fail");
    $finish;
  end

  // result side: random stall, plus a long hold-off on request
  initial begin
    int unsigned holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 32);
      end
    end
  end

  // random idle gap, each further idle cycle with about one-third chance, unless calm
  function automatic int unsigned idle_gap();
    int unsigned g;
    g = 0;
    if (calm) return 0;
    while ($urandom_range(99) < 32) g++;
    return g;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return COORD_W'($urandom_range(0, 1023));
  endfunction

  function automatic int unsigned pick_size();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0: return 0;
      1: return 1;
      2: return 1024;
      3: return 2047;
      default: return $urandom_range(1, 1024);
    endcase
  endfunction

  function automatic int unsigned pick_run();
    return ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
  endfunction

  // one sample beat; valid stays high into the next beat unless idling
  task automatic send_sample(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic t);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    touch_x  <= x;
    touch_y  <= y;
    touched  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_touch();
    send_sample(rand_coord(), rand_coord(), 1'b1);
  endtask

  task automatic send_lift();
    send_sample(rand_coord(), rand_coord(), 1'b0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_setup(input int unsigned w, input int unsigned h,
                             input int unsigned p, input int unsigned r,
                             input int unsigned lim);
    write_reg(REG_CELL_WIDTH,   CFG_DATA_BITS'(w));
    write_reg(REG_CELL_HEIGHT,  CFG_DATA_BITS'(h));
    write_reg(REG_PRESS_RUNS,   CFG_DATA_BITS'(p));
    write_reg(REG_RELEASE_RUNS, CFG_DATA_BITS'(r));
    write_reg(REG_LONG_LIMIT,   CFG_DATA_BITS'(lim));
    cfg_we       <= 1'b0;
    press_need   = (p == 0) ? 1 : p;
    release_need = (r == 0) ? 1 : r;
  endtask

  // wait for every report, then let any result-free beat finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  // well-formed gesture with random content
  task automatic send_gesture();
    int unsigned n;
    int unsigned k;
    // false start: touched run cut short
    if (press_need > 1 && $urandom_range(3) == 0) begin
      n = $urandom_range(1, press_need - 1);
      repeat (n) send_touch();
      send_lift();
    end
    repeat (press_need) send_touch();
    // bounces while held: lifts too short to release
    n = $urandom_range(0, 4);
    repeat (n) begin
      k = $urandom_range(0, release_need - 1);
      repeat (k) send_lift();
      repeat ($urandom_range(1, 3)) send_touch();
    end
    repeat (release_need) send_lift();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_sample(rand_coord(), rand_coord(), 1'($urandom_range(1)));
  endtask

  initial begin
    int unsigned phase;
    int unsigned rand_start;
    int unsigned p;
    int unsigned r;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unit cells, runs of ten, coordinate extremes
    send_sample(10'd0,    10'd0,    1'b1);
    send_sample(10'd1023, 10'd1023, 1'b1);
    send_sample(10'd1023, 10'd0,    1'b1);
    send_sample(10'd0,    10'd1023, 1'b1);
    send_sample(10'd1,    10'd2,    1'b1);
    send_sample(10'd512,  10'd256,  1'b1);
    send_sample(10'd683,  10'd170,  1'b1);
    send_sample(10'd85,   10'd938,  1'b1);
    send_sample(10'd1022, 10'd1,    1'b1);
    send_sample(10'd341,  10'd682,  1'b1);
    repeat (10) send_lift();
    settle();

    // zero cell sizes and zero run lengths act as one, limit zero
    apply_setup(0, 0, 0, 0, 0);
    send_sample(10'd1023, 10'd1023, 1'b1);
    send_sample(10'd0,    10'd0,    1'b0);
    settle();

    // cell sizes past the nominal range
    apply_setup(2047, 1024, 1, 1, 1);
    send_sample(10'd1023, 10'd1023, 1'b1);
    send_sample(10'd1023, 10'd0,    1'b1);
    send_sample(10'd512,  10'd512,  1'b0);
    settle();

    // longest press run after a false start, touched count just past the limit
    apply_setup(2047, 1, 255, 20, 256);
    calm = 1'b1;
    repeat (254) send_touch();
    send_lift();
    repeat (LONG_TOUCHES) send_touch();
    repeat (19) send_lift();
    send_sample(10'd700, 10'd900, 1'b1);
    repeat (20) send_lift();
    settle();
    calm = 1'b0;

    // random gestures, new settings per phase
    rand_start = beats_sent;
    for (phase = 0; beats_sent - rand_start < RANDOM_BEATS; phase++) begin
      calm = (phase == 1);
      case (phase)
        0: apply_setup(1, 1, 1, 1, 0);
        1: apply_setup(1024, 1024, 3, 2, 4);
        default: begin
          p = pick_run();
          r = pick_run();
          apply_setup(pick_size(), pick_size(), p, r, $urandom_range(0, 3 * p + 6));
        end
      endcase
      // short runs make reports frequent, so a hold-off backs up the input
      if (phase == 0) hold_requests++;
      repeat ((phase == 0) ? 12 : 6) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_gesture();
      end
      settle();
    end
    calm = 1'b0;

    if (error_count == 0 && reports_due == 0)
      $display("touch_grid_debounce_long_press_unit regression: pass");
    else
      $display("touch_grid_debounce_long_press_unit regression: fail");
    $finish;
  end

endmodule

>>> files.f
sv/tgdlp_pkg.sv
sv/tgdlp_ctrl.sv
sv/tgdlp_dp.sv
sv/touch_grid_debounce_long_press_unit.sv
tb/sv/tgdlp_gesture_checker.sv
tb/sv/tb_touch_grid_debounce_long_press_unit.sv
